@@ src/i2cram_pkg.sv @@
package i2cram_pkg;

    // Command codes carried in the action field
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Read/write flag appended to the device address
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    localparam logic [3:0] BYTE_BITS = 4'd8;

    localparam logic [1:0] BYTE_DEV  = 2'd0;
    localparam logic [1:0] BYTE_REG  = 2'd1;
    localparam logic [1:0] BYTE_DATA = 2'd2;

    // Bus sequencer steps; each lasts one delay unit
    typedef enum logic [4:0] {
        ST_IDLE = 5'd0,
        ST_S0A  = 5'd1,
        ST_S0B  = 5'd2,
        ST_S1A  = 5'd3,
        ST_S1B  = 5'd4,
        ST_B0A  = 5'd5,
        ST_B0B  = 5'd6,
        ST_B1A  = 5'd7,
        ST_B1B  = 5'd8,
        ST_B2   = 5'd9,
        ST_A0A  = 5'd10,
        ST_A0B  = 5'd11,
        ST_A1A  = 5'd12,
        ST_A1B  = 5'd13,
        ST_R0A  = 5'd14,
        ST_R0B  = 5'd15,
        ST_R1A  = 5'd16,
        ST_R1B  = 5'd17,
        ST_N0A  = 5'd18,
        ST_N0B  = 5'd19,
        ST_N1A  = 5'd20,
        ST_N1B  = 5'd21,
        ST_P0A  = 5'd22,
        ST_P0B  = 5'd23,
        ST_P1A  = 5'd24,
        ST_P1B  = 5'd25,
        ST_P2A  = 5'd26,
        ST_P2B  = 5'd27
    } step_t;

    typedef struct packed {
        logic clear;
        logic count;
    } timer_ctl_t;

endpackage

@@ src/i2cram_timer.sv @@
module i2cram_timer
    import i2cram_pkg::*;
#(
    parameter int TICK_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] unit_ticks,
    input  timer_ctl_t  ctl,
    output logic        unit_end
);

    localparam int UW = (TICK_BITS > 16) ? TICK_BITS : 16;

    logic [TICK_BITS-1:0] tick_reg;
    logic [TICK_BITS-1:0] tick_next;
    logic [TICK_BITS-1:0] tick_inc;
    logic [TICK_BITS-1:0] unit_eff;
    logic [15:0]          unit_nz;
    logic [UW-1:0]        unit_wide;
    logic [UW-1:0]        cap_wide;
    logic [UW-1:0]        unit_sat;

    // A zero unit acts as one; clamp to what the counter can hold
    always_comb
    begin
        unit_nz   = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
        unit_wide = UW'(unit_nz);
        cap_wide  = UW'({TICK_BITS{1'b1}});
        unit_sat  = (unit_wide > cap_wide) ? cap_wide : unit_wide;
        unit_eff  = unit_sat[TICK_BITS-1:0];
        tick_inc  = tick_reg + TICK_BITS'(1);
        unit_end  = (tick_inc >= unit_eff);
    end

    always_comb
    begin
        tick_next = tick_reg;
        if (ctl.clear)
        begin
            tick_next = '0;
        end
        else if (ctl.count)
        begin
            tick_next = unit_end ? '0 : tick_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
        end
        else
        begin
            tick_reg <= tick_next;
        end
    end

endmodule

@@ src/i2cram_seq.sv @@
module i2cram_seq
    import i2cram_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [1:0] action,
    input  logic [6:0] dev_addr,
    input  logic [7:0] reg_addr,
    input  logic [7:0] wr_data,
    input  logic       sda_in,
    input  logic       unit_end,
    output timer_ctl_t timer_ctl,
    output logic       scl_res,
    output logic       sda_res,
    output logic       busy_res,
    output logic       done_res,
    output logic       status_res,
    output logic [7:0] rd_res,
    output logic       rej_res
);

    step_t      step_reg,    step_next;
    logic [3:0] bit_reg,     bit_next;
    logic [1:0] byte_reg,    byte_next;
    logic [7:0] shift_reg,   shift_next;
    logic       rmode_reg,   rmode_next;
    logic       failed_reg,  failed_next;
    logic [7:0] rx_reg,      rx_next;
    logic [6:0] dev_reg,     dev_next;
    logic [7:0] raddr_reg,   raddr_next;
    logic [7:0] data_reg,    data_next;

    logic       is_cmd;
    logic       is_tick;
    logic       idle;
    logic       finish;
    logic [3:0] bit_inc;

    assign is_cmd  = (action == ACT_WRITE) || (action == ACT_READ);
    assign is_tick = (action == ACT_TICK);
    assign idle    = (step_reg == ST_IDLE);
    assign finish  = fire && is_tick && !idle && unit_end;
    assign bit_inc = bit_reg + 4'd1;

    // Line drive for a step: {scl, sda}
    function automatic logic [1:0] line_drive(step_t s, logic msb);
        logic scl;
        logic sda;
        begin
            unique case (s)
                ST_B0A, ST_B0B, ST_B2, ST_A0A, ST_A0B, ST_R1A, ST_R1B,
                ST_N0A, ST_N0B, ST_P0A, ST_P0B: scl = 1'b0;
                default:                        scl = 1'b1;
            endcase
            unique case (s)
                ST_S1A, ST_S1B, ST_P0A, ST_P0B, ST_P1A, ST_P1B: sda = 1'b0;
                ST_B0A, ST_B0B, ST_B1A, ST_B1B, ST_B2:          sda = msb;
                default:                                        sda = 1'b1;
            endcase
            line_drive = {scl, sda};
        end
    endfunction

    // Next state
    always_comb
    begin
        step_next   = step_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        shift_next  = shift_reg;
        rmode_next  = rmode_reg;
        failed_next = failed_reg;
        rx_next     = rx_reg;
        dev_next    = dev_reg;
        raddr_next  = raddr_reg;
        data_next   = data_reg;

        if (fire && is_cmd && idle)
        begin
            dev_next    = dev_addr;
            raddr_next  = reg_addr;
            data_next   = wr_data;
            rmode_next  = (action == ACT_READ);
            failed_next = 1'b0;
            byte_next   = BYTE_DEV;
            shift_next  = {dev_addr, RW_WRITE};
            bit_next    = 4'd0;
            step_next   = ST_S0A;
        end
        else if (finish)
        begin
            unique case (step_reg)
                ST_S1B:
                begin
                    bit_next  = 4'd0;
                    step_next = ST_B0A;
                end
                ST_B2:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next   = bit_inc;
                    step_next  = (bit_inc >= BYTE_BITS) ? ST_A0A : ST_B0A;
                end
                ST_A1B:
                begin
                    if (sda_in)
                    begin
                        failed_next = 1'b1;
                        step_next   = ST_P0A;
                    end
                    else
                    begin
                        byte_next = byte_reg + 2'd1;
                        if (byte_reg == BYTE_DEV)
                        begin
                            shift_next = raddr_reg;
                            bit_next   = 4'd0;
                            step_next  = ST_B0A;
                        end
                        else if (byte_reg == BYTE_REG)
                        begin
                            bit_next = 4'd0;
                            if (rmode_reg)
                            begin
                                shift_next = {dev_reg, RW_READ};
                                step_next  = ST_S0A;
                            end
                            else
                            begin
                                shift_next = data_reg;
                                step_next  = ST_B0A;
                            end
                        end
                        else if (byte_reg == BYTE_DATA && rmode_reg)
                        begin
                            shift_next = 8'd0;
                            bit_next   = 4'd0;
                            step_next  = ST_R0A;
                        end
                        else
                        begin
                            step_next = ST_P0A;
                        end
                    end
                end
                ST_R0B:
                begin
                    shift_next = {shift_reg[6:0], sda_in};
                    step_next  = ST_R1A;
                end
                ST_R1B:
                begin
                    bit_next = bit_inc;
                    if (bit_inc >= BYTE_BITS)
                    begin
                        rx_next   = shift_reg;
                        step_next = ST_N0A;
                    end
                    else
                    begin
                        step_next = ST_R0A;
                    end
                end
                ST_N1B: step_next = ST_P0A;
                ST_P2B: step_next = ST_IDLE;
                ST_S0A, ST_S0B, ST_S1A, ST_B0A, ST_B0B, ST_B1A, ST_B1B,
                ST_A0A, ST_A0B, ST_A1A, ST_R0A, ST_R1A, ST_N0A, ST_N0B,
                ST_N1A, ST_P0A, ST_P0B, ST_P1A, ST_P1B, ST_P2A:
                    step_next = step_t'(step_reg + 5'd1);
                default: step_next = ST_IDLE;
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        timer_ctl.clear      = fire && is_cmd && idle;
        timer_ctl.count      = fire && is_tick && !idle;
        {scl_res, sda_res}   = line_drive(step_next, shift_next[7]);
        busy_res             = (step_next != ST_IDLE);
        done_res             = finish && (step_reg == ST_P2B);
        status_res           = failed_next;
        rd_res               = rx_next;
        rej_res              = fire && is_cmd && !idle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= ST_IDLE;
            bit_reg    <= 4'd0;
            byte_reg   <= 2'd0;
            rmode_reg  <= 1'b0;
            failed_reg <= 1'b0;
            rx_reg     <= 8'd0;
        end
        else
        begin
            step_reg   <= step_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            rmode_reg  <= rmode_next;
            failed_reg <= failed_next;
            rx_reg     <= rx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        dev_reg   <= dev_next;
        raddr_reg <= raddr_next;
        data_reg  <= data_next;
    end

    a_read_steps_need_read_mode: assert property (
        @(posedge clk) disable iff (!rst_n)
        (step_reg >= ST_R0A && step_reg <= ST_N1B) |-> rmode_reg
    ) else $error("read phase entered on a write transaction");

    a_bit_index_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        bit_reg <= BYTE_BITS
    ) else $error("bit index ran past one byte");

    a_cmd_starts_at_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fire && is_cmd && idle) |=> (step_reg == ST_S0A)
    ) else $error("accepted command did not start the bus sequence");

endmodule

@@ src/i2c_register_access_master_unit.sv @@
// Single-byte register access master for an open-drain two-wire bus.
// Input channel (in_valid/in_ready): each beat is either a tick, carrying
// the sampled SDA level, or a write/read command with device address,
// register address and write byte. Commands while a transaction runs are
// dropped and flagged with cmd_rejected; action code three does nothing.
// Output channel (out_valid/out_ready): one beat per input beat, showing
// SCL/SDA drive, busy, a done pulse, status and the last read byte.
// unit_ticks (cfg_we/cfg_wdata) sets ticks per delay unit; write it while idle.
// An accepted beat lands in the input register and its result is loaded
// into the output register once that is free, so out_valid rises after the
// beat has passed both registers. Throughput: one beat per cycle while the
// receiver takes each output beat.
// A stalled receiver holds the output register; the input register then
// fills and in_ready drops until the output beat is taken.
// Reset clears the sequencer to idle with both lines released, status and
// read byte zero, and unit_ticks to 50.
module i2c_register_access_master_unit
    import i2cram_pkg::*;
#(
    parameter int TICK_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [6:0]  dev_addr,
    input  logic [7:0]  reg_addr,
    input  logic [7:0]  wr_data,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_out,
    output logic        sda_out,
    output logic        busy_res,
    output logic        done_res,
    output logic        status,
    output logic [7:0]  read_data,
    output logic        cmd_rejected
);

    logic [15:0] unit_reg;

    logic        a_valid_reg, a_valid_next;
    logic [1:0]  a_action_reg;
    logic [6:0]  a_dev_reg;
    logic [7:0]  a_raddr_reg;
    logic [7:0]  a_data_reg;
    logic        a_sda_reg;

    logic        out_valid_reg, out_valid_next;
    logic        scl_reg, sda_reg, busy_reg, done_reg, status_reg, rej_reg;
    logic [7:0]  rd_reg;

    logic        b_ready;
    logic        fire;
    logic        in_fire;
    logic        unit_end;
    timer_ctl_t  timer_ctl;
    logic        scl_res, sda_res, busy_c, done_c, status_c, rej_c;
    logic [7:0]  rd_c;

    assign b_ready  = !out_valid_reg || out_ready;
    assign fire     = a_valid_reg && b_ready;
    assign in_ready = !a_valid_reg || b_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_fire)
        begin
            a_valid_next = 1'b1;
        end
        else if (fire)
        begin
            a_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    i2cram_timer #(
        .TICK_BITS (TICK_BITS)
    ) u_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_ticks (unit_reg),
        .ctl        (timer_ctl),
        .unit_end   (unit_end)
    );

    i2cram_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .action     (a_action_reg),
        .dev_addr   (a_dev_reg),
        .reg_addr   (a_raddr_reg),
        .wr_data    (a_data_reg),
        .sda_in     (a_sda_reg),
        .unit_end   (unit_end),
        .timer_ctl  (timer_ctl),
        .scl_res    (scl_res),
        .sda_res    (sda_res),
        .busy_res   (busy_c),
        .done_res   (done_c),
        .status_res (status_c),
        .rd_res     (rd_c),
        .rej_res    (rej_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg      <= 16'd50;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unit_reg <= cfg_wdata;
            end
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold until the stage advances
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_action_reg <= action;
            a_dev_reg    <= dev_addr;
            a_raddr_reg  <= reg_addr;
            a_data_reg   <= wr_data;
            a_sda_reg    <= sda_in;
        end
        if (fire)
        begin
            scl_reg    <= scl_res;
            sda_reg    <= sda_res;
            busy_reg   <= busy_c;
            done_reg   <= done_c;
            status_reg <= status_c;
            rd_reg     <= rd_c;
            rej_reg    <= rej_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_out      = scl_reg;
    assign sda_out      = sda_reg;
    assign busy_res     = busy_reg;
    assign done_res     = done_reg;
    assign status       = status_reg;
    assign read_data    = rd_reg;
    assign cmd_rejected = rej_reg;

    a_done_means_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res
    ) else $error("done reported while transaction still busy");

    a_reject_only_when_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && cmd_rejected) |-> busy_res
    ) else $error("command rejected while idle");

    a_held_beat_kept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_ready) |=> a_valid_reg
    ) else $error("input beat dropped while output stalled");

endmodule

@@ tb/i2c_register_access_master_unit_tb.sv @@
module i2c_register_access_master_unit_tb;
    import i2cram_pkg::*;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] dev;
        logic [7:0] regad;
        logic [7:0] wbyte;
        logic       sda;
    } bus_cmd_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic       status;
        logic [7:0] rdata;
        logic       rejected;
    } bus_obs_t;

    typedef struct packed {
        bus_cmd_t cmd;
        bus_obs_t obs;
    } planned_beat_t;

    typedef struct packed {
        bus_cmd_t cmd;
        logic     has_obs;
        bus_obs_t obs;
    } table_row_t;

    typedef struct packed {
        logic [15:0] unit_len;
        logic [15:0] tick_cnt;
        step_t       cur_step;
        logic [3:0]  bit_no;
        logic [1:0]  byte_no;
        logic [7:0]  shreg;
        logic        rd_mode;
        logic        nacked;
        logic [7:0]  rx_byte;
        logic [6:0]  dev;
        logic [7:0]  regad;
        logic [7:0]  wbyte;
        logic        scl_lv;
        logic        sda_lv;
    } bus_mirror_t;

    localparam bus_obs_t IDLE_OBS = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
    localparam bus_obs_t BUSY_OBS = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
    localparam bus_obs_t REJ_OBS  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1};
    localparam int RANDOM_ITEMS = 350;
    localparam int PHASE_ITEMS  = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ACT_TICK;
    logic [6:0]  dev_addr = 7'd0;
    logic [7:0]  reg_addr = 8'd0;
    logic [7:0]  wr_data = 8'd0;
    logic        sda_in = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic [7:0]  read_data;
    logic        cmd_rejected;

    bus_mirror_t   bus;
    planned_beat_t beat_q[$];
    bus_obs_t      result_q[$];
    planned_beat_t taken_beat;
    bus_obs_t      want_obs;
    bus_obs_t      got_obs;
    int            mismatch_count = 0;
    int            planned_count = 0;
    bit            holding = 1'b0;
    int            gap_left = 0;
    int            burst_left = 0;
    int            stall_left = 0;
    int            stall_mode = 0;
    logic [7:0]    stall_pat = 8'hFF;
    logic [2:0]    pat_pos = 3'd0;

    table_row_t dir_rows [0:10] = '{
        '{'{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b0}, 1'b1, IDLE_OBS},
        '{'{ACT_TICK,  7'h7F, 8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_OBS},
        '{'{ACT_NONE,  7'h7F, 8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_OBS},
        '{'{ACT_NONE,  7'h00, 8'h00, 8'h00, 1'b0}, 1'b1, IDLE_OBS},
        '{'{ACT_WRITE, 7'h7F, 8'hFF, 8'hFF, 1'b0}, 1'b1, BUSY_OBS},
        '{'{ACT_READ,  7'h00, 8'h00, 8'h00, 1'b0}, 1'b1, REJ_OBS},
        '{'{ACT_WRITE, 7'h00, 8'h00, 8'h00, 1'b1}, 1'b1, REJ_OBS},
        '{'{ACT_NONE,  7'h7F, 8'hFF, 8'hFF, 1'b1}, 1'b1, BUSY_OBS},
        '{'{ACT_TICK,  7'h00, 8'h00, 8'h00, 1'b0}, 1'b0, IDLE_OBS},
        '{'{ACT_TICK,  7'h55, 8'hAA, 8'h55, 1'b1}, 1'b0, IDLE_OBS},
        '{'{ACT_READ,  7'h7F, 8'hFF, 8'hFF, 1'b1}, 1'b1, REJ_OBS}
    };

    i2c_register_access_master_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .dev_addr     (dev_addr),
        .reg_addr     (reg_addr),
        .wr_data      (wr_data),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_out      (scl_out),
        .sda_out      (sda_out),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .status       (status),
        .read_data    (read_data),
        .cmd_rejected (cmd_rejected)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Line levels are latched on entry to a step and held for its whole length.
    function automatic void enter_step(input step_t s);
        bus.cur_step = s;
        bus.scl_lv = !(s inside {ST_B0A, ST_B0B, ST_B2, ST_A0A, ST_A0B, ST_R1A, ST_R1B,
                                 ST_N0A, ST_N0B, ST_P0A, ST_P0B});
        if (s inside {ST_B0A, ST_B0B, ST_B1A, ST_B1B, ST_B2})
            bus.sda_lv = bus.shreg[7];
        else if (s inside {ST_S1A, ST_S1B, ST_P0A, ST_P0B, ST_P1A, ST_P1B})
            bus.sda_lv = 1'b0;
        else
            bus.sda_lv = 1'b1;
    endfunction

    function automatic void reset_mirror();
        bus = '0;
        bus.unit_len = 16'd50;
        enter_step(ST_IDLE);
    endfunction

    function automatic string obs_text(input bus_obs_t o);
        return $sformatf("scl %0b sda %0b busy %0b done %0b status %0b data %02h rej %0b",
                         o.scl, o.sda, o.busy, o.done, o.status, o.rdata, o.rejected);
    endfunction

    // End of the last tick of a step; returns the done pulse.
    function automatic logic close_step(input logic sda);
        logic [1:0] acked_byte;
        close_step = 1'b0;
        case (bus.cur_step)
            ST_S1B:
            begin
                bus.bit_no = 4'd0;
                enter_step(ST_B0A);
            end
            ST_B2:
            begin
                bus.shreg = {bus.shreg[6:0], 1'b0};
                bus.bit_no = bus.bit_no + 4'd1;
                enter_step((bus.bit_no >= BYTE_BITS) ? ST_A0A : ST_B0A);
            end
            ST_A1B:
            begin
                if (sda) begin
                    bus.nacked = 1'b1;
                    enter_step(ST_P0A);
                end else begin
                    acked_byte = bus.byte_no;
                    bus.byte_no = bus.byte_no + 2'd1;
                    if (acked_byte == BYTE_DEV) begin
                        bus.shreg = bus.regad;
                        bus.bit_no = 4'd0;
                        enter_step(ST_B0A);
                    end else if (acked_byte == BYTE_REG && bus.rd_mode) begin
                        // repeated start, then address with the read flag
                        bus.shreg = {bus.dev, RW_READ};
                        bus.bit_no = 4'd0;
                        enter_step(ST_S0A);
                    end else if (acked_byte == BYTE_REG) begin
                        bus.shreg = bus.wbyte;
                        bus.bit_no = 4'd0;
                        enter_step(ST_B0A);
                    end else if (acked_byte == BYTE_DATA && bus.rd_mode) begin
                        bus.shreg = 8'd0;
                        bus.bit_no = 4'd0;
                        enter_step(ST_R0A);
                    end else begin
                        enter_step(ST_P0A);
                    end
                end
            end
            ST_R0B:
            begin
                bus.shreg = {bus.shreg[6:0], sda};
                enter_step(ST_R1A);
            end
            ST_R1B:
            begin
                bus.bit_no = bus.bit_no + 4'd1;
                if (bus.bit_no >= BYTE_BITS) begin
                    bus.rx_byte = bus.shreg;
                    enter_step(ST_N0A);
                end else begin
                    enter_step(ST_R0A);
                end
            end
            ST_N1B: enter_step(ST_P0A);
            ST_P2B:
            begin
                enter_step(ST_IDLE);
                close_step = 1'b1;
            end
            default: enter_step(step_t'(bus.cur_step + 5'd1));
        endcase
    endfunction

    function automatic bus_obs_t advance_bus(input bus_cmd_t c);
        bus_obs_t    r;
        logic [15:0] span;
        r = '0;
        if (c.action == ACT_WRITE || c.action == ACT_READ) begin
            if (bus.cur_step != ST_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                bus.dev = c.dev;
                bus.regad = c.regad;
                bus.wbyte = c.wbyte;
                bus.rd_mode = (c.action == ACT_READ);
                bus.nacked = 1'b0;
                bus.byte_no = 2'd0;
                bus.tick_cnt = 16'd0;
                bus.shreg = {c.dev, RW_WRITE};
                bus.bit_no = 4'd0;
                enter_step(ST_S0A);
            end
        end else if (c.action == ACT_TICK && bus.cur_step != ST_IDLE) begin
            // a zero unit length counts as one tick
            span = (bus.unit_len == 16'd0) ? 16'd1 : bus.unit_len;
            bus.tick_cnt = bus.tick_cnt + 16'd1;
            if (bus.tick_cnt >= span) begin
                bus.tick_cnt = 16'd0;
                r.done = close_step(c.sda);
            end
        end
        r.scl = bus.scl_lv;
        r.sda = bus.sda_lv;
        r.busy = (bus.cur_step != ST_IDLE);
        r.status = bus.nacked;
        r.rdata = bus.rx_byte;
        return r;
    endfunction

    function automatic void plan_beat(input bus_cmd_t c, input logic has_obs,
                                      input bus_obs_t fixed_obs);
        planned_beat_t b;
        b.cmd = c;
        b.obs = advance_bus(c);
        if (has_obs)
            b.obs = fixed_obs;
        beat_q.push_back(b);
        planned_count++;
    endfunction

    function automatic bus_cmd_t rand_cmd(input logic [1:0] act);
        bus_cmd_t c;
        c.action = act;
        c.dev = 7'($urandom_range(0, 127));
        c.regad = 8'($urandom_range(0, 255));
        c.wbyte = 8'($urandom_range(0, 255));
        c.sda = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic wait_drained();
        while (beat_q.size() != 0 || result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_unit(input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        bus.unit_len = value;
    endtask

    // Tick the bus through to stop; the target mostly acknowledges.
    task automatic run_to_idle();
        bus_cmd_t c;
        while (bus.cur_step != ST_IDLE) begin
            case ($urandom_range(0, 59))
                0: c = rand_cmd($urandom_range(0, 1) ? ACT_WRITE : ACT_READ);
                1: c = rand_cmd(ACT_NONE);
                default:
                begin
                    c = rand_cmd(ACT_TICK);
                    if (bus.cur_step == ST_A1B)
                        c.sda = ($urandom_range(0, 11) == 0);
                end
            endcase
            plan_beat(c, 1'b0, IDLE_OBS);
            if ($urandom_range(0, 299) == 0)
                wait_drained();
        end
    endtask

    task automatic run_transaction();
        repeat ($urandom_range(0, 3))
            plan_beat(rand_cmd($urandom_range(0, 1) ? ACT_TICK : ACT_NONE), 1'b0, IDLE_OBS);
        plan_beat(rand_cmd($urandom_range(0, 1) ? ACT_WRITE : ACT_READ), 1'b0, IDLE_OBS);
        run_to_idle();
    endtask

    // Sender: bursts of beats separated by random gaps.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                taken_beat = beat_q.pop_front();
                result_q.push_back(taken_beat.obs);
                holding = 1'b0;
            end
            if (!holding && beat_q.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    action <= beat_q[0].cmd.action;
                    dev_addr <= beat_q[0].cmd.dev;
                    reg_addr <= beat_q[0].cmd.regad;
                    wr_data <= beat_q[0].cmd.wbyte;
                    sda_in <= beat_q[0].cmd.sda;
                    holding = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= holding;
        end
    end

    // Receiver: windows of always-ready, a fixed stall pattern, or coin flips.
    always @(posedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 96);
            stall_pat = 8'($urandom_range(0, 255));
        end
        stall_left--;
        pat_pos = pat_pos + 3'd1;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= stall_pat[pat_pos];
            default: out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            got_obs = '{scl_out, sda_out, busy_res, done_res, status, read_data, cmd_rejected};
            if (result_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: %s", obs_text(got_obs));
            end else begin
                want_obs = result_q.pop_front();
                if (got_obs.scl !== want_obs.scl || got_obs.sda !== want_obs.sda ||
                    got_obs.busy !== want_obs.busy || got_obs.done !== want_obs.done ||
                    got_obs.status !== want_obs.status || got_obs.rdata !== want_obs.rdata ||
                    got_obs.rejected !== want_obs.rejected) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp %s", obs_text(want_obs));
                        $display("          got %s", obs_text(got_obs));
                    end
                end
            end
        end
    end

    initial
    begin
        #60000000;
        $display("i2c_register_access_master_unit regression: fail");
        $finish;
    end

    initial
    begin
        logic [15:0] unit_menu [0:7];
        int          phase_no;
        int          start_count;
        int          phase_start;
        unit_menu = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd0, 16'd1, 16'd2, 16'd1};
        reset_mirror();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows run at the reset unit length
        for (int i = 0; i <= 10; i++)
            plan_beat(dir_rows[i].cmd, dir_rows[i].has_obs, dir_rows[i].obs);
        // shorten the unit to finish the open transaction quickly
        wait_drained();
        write_unit(16'd1);
        run_to_idle();

        phase_no = 0;
        start_count = planned_count;
        while (planned_count - start_count < RANDOM_ITEMS) begin
            wait_drained();
            if ($urandom_range(0, 3) == 0)
                write_unit(16'($urandom_range(1, 2)));
            else
                write_unit(unit_menu[phase_no % 8]);
            phase_no++;
            phase_start = planned_count;
            while (planned_count - phase_start < PHASE_ITEMS &&
                   planned_count - start_count < RANDOM_ITEMS)
                run_transaction();
        end

        // longest unit: the first step holds across a run of ticks
        wait_drained();
        write_unit(16'hFFFF);
        plan_beat(rand_cmd(ACT_READ), 1'b0, IDLE_OBS);
        repeat (40)
            plan_beat(rand_cmd(ACT_TICK), 1'b0, IDLE_OBS);
        wait_drained();
        write_unit(16'd0);
        run_to_idle();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && result_q.size() == 0)
            $display("i2c_register_access_master_unit regression: pass");
        else
            $display("i2c_register_access_master_unit regression: fail");
        $finish;
    end

endmodule
